// ===== hw/rtl/prcs_pkg.sv =====
`timescale 1ns / 1ps

package prcs_pkg;

    localparam int CHAR_W     = 7;
    localparam int GEN_W      = 17;
    localparam int START_W    = 16;
    localparam int PROD_W     = 23;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 8;

    localparam logic [6:0]        GEN_MULT   = 7'd75;
    localparam logic [GEN_W-1:0]  GEN_MOD    = 17'd65537;
    localparam logic [GEN_W-1:0]  GEN_RESET  = 17'd1;
    localparam logic [START_W-1:0] START_RESET = 16'd1;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 7'd32;
    localparam logic [7:0]        PRINT_SPAN = 8'd96;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DECRYPT_MODE = 1'b0,
        REG_START_VALUE  = 1'b1
    } cfg_reg_t;

    // One rotation request handed to the rotate stage.
    typedef struct packed {
        logic [GEN_W-1:0]  key;
        logic [CHAR_W-1:0] char_in;
        logic              decrypt;
    } rot_req_t;

    // g*75 mod 65537: fold low 16 bits minus high bits, add modulus on borrow.
    function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
        logic [PROD_W-1:0] p;
        logic [GEN_W-1:0]  lo;
        logic [GEN_W-1:0]  hi;
        p  = PROD_W'(g) * PROD_W'(GEN_MULT);
        lo = {1'b0, p[15:0]};
        hi = GEN_W'(p[PROD_W-1:16]);
        if (lo < hi) begin
            gen_advance = lo + GEN_MOD - hi;
        end else begin
            gen_advance = lo - hi;
        end
    endfunction

    // g mod 96 = (g/32 mod 3)*32 + g mod 32; mod 3 by summing base-4 digits.
    function automatic logic [6:0] key_mod96(input logic [GEN_W-1:0] g);
        logic [11:0] q;
        logic [4:0]  s1;
        logic [2:0]  s2;
        logic [2:0]  s3;
        logic [1:0]  r;
        q  = g[GEN_W-1:5];
        s1 = 5'(q[1:0]) + 5'(q[3:2]) + 5'(q[5:4]) + 5'(q[7:6]) + 5'(q[9:8]) + 5'(q[11:10]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        r  = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
        key_mod96 = {r, g[4:0]};
    endfunction

endpackage

// ===== hw/rtl/prcs_rotate.sv =====
`timescale 1ns / 1ps

module prcs_rotate (
    input  prcs_pkg::rot_req_t                req,
    output logic [prcs_pkg::CHAR_W-1:0]       char_out
);

    logic [6:0] shift;
    logic [6:0] pos;
    logic [7:0] fwd;
    logic [7:0] bwd;
    logic [7:0] rot;

    always_comb begin
        shift = prcs_pkg::key_mod96(req.key);
        pos   = req.char_in - prcs_pkg::PRINT_LO;
        fwd   = {1'b0, pos} + {1'b0, shift};
        bwd   = {1'b0, pos} - {1'b0, shift};
        if (req.decrypt) begin
            rot = bwd[7] ? (bwd + prcs_pkg::PRINT_SPAN) : bwd;
        end else begin
            rot = (fwd >= prcs_pkg::PRINT_SPAN) ? (fwd - prcs_pkg::PRINT_SPAN) : fwd;
        end
        // control characters pass unchanged
        if (req.char_in < prcs_pkg::PRINT_LO) begin
            char_out = req.char_in;
        end else begin
            char_out = rot[6:0] + prcs_pkg::PRINT_LO;
        end
    end

endmodule

// ===== hw/rtl/prng_rotation_stream_cipher.sv =====
`timescale 1ns / 1ps
// An accepted request is registered in the key stage, then in the result stage,
// whose register drives m_tvalid. One character per cycle unless m_tready stalls;
// the generator step (constant multiply and fold) closes its loop on gen_reg.
// Reset (aresetn low, synchronous): pipeline empty, generator = 1,
// decrypt_mode = 0, start_value = 1.

module prng_rotation_stream_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [prcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [prcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prcs_pkg::TDATA_W-1:0]        s_tdata,   // [6:0] char_in, [7] zero
    input  logic                                s_tuser,   // [0] restart
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prcs_pkg::TDATA_W-1:0]        m_tdata    // [6:0] char_out, [7] zero
);

    // configuration registers
    logic                              decrypt_reg;
    logic [prcs_pkg::START_W-1:0]      start_reg;

    // generator state
    logic [prcs_pkg::GEN_W-1:0]        gen_reg;
    logic [prcs_pkg::GEN_W-1:0]        gen_next;
    logic [prcs_pkg::GEN_W-1:0]        gen_base;

    // key stage: keyed character waiting for rotation
    logic                              key_valid_reg;
    logic [prcs_pkg::GEN_W-1:0]        key_reg;
    logic [prcs_pkg::CHAR_W-1:0]       char_reg;

    // result stage
    logic                              out_valid_reg;
    logic [prcs_pkg::CHAR_W-1:0]       out_char_reg;
    logic [prcs_pkg::CHAR_W-1:0]       out_char_next;

    logic                              s_accept;
    logic                              out_load;
    prcs_pkg::rot_req_t                rot_req;

    // Advance a stage whenever the stage after it is empty or draining.
    assign out_load  = !out_valid_reg || m_tready;
    assign s_tready  = !key_valid_reg || out_load;
    assign s_accept  = s_tvalid && s_tready;

    // Reload from start_value on restart, then take one generator step.
    assign gen_base = s_tuser ? {1'b0, start_reg} : gen_reg;
    assign gen_next = prcs_pkg::gen_advance(gen_base);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
            start_reg   <= prcs_pkg::START_RESET;
        end else if (cfg_we) begin
            case (prcs_pkg::cfg_reg_t'(cfg_addr))
                prcs_pkg::REG_DECRYPT_MODE: decrypt_reg <= cfg_wdata[0];
                prcs_pkg::REG_START_VALUE:  start_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Generator moves exactly once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= prcs_pkg::GEN_RESET;
        end else if (s_accept) begin
            gen_reg <= gen_next;
        end
    end

    // Key stage: hold the fresh key and character until the result stage takes them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_valid_reg <= 1'b0;
        end else if (s_tready) begin
            key_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg  <= gen_next;
            char_reg <= s_tdata[prcs_pkg::CHAR_W-1:0];
        end
    end

    // Rotate within the printable range.
    assign rot_req.key     = key_reg;
    assign rot_req.char_in = char_reg;
    assign rot_req.decrypt = decrypt_reg;

    prcs_rotate u_rotate (
        .req      (rot_req),
        .char_out (out_char_next)
    );

    // Result stage: hold until the consumer takes the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= key_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && key_valid_reg) begin
            out_char_reg <= out_char_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};

endmodule
